### hdl/rse_pkg.sv
package rse_pkg;

    localparam int OperandWidth = 64;
    localparam int FracWidth    = 52;
    localparam int ExpWidth     = 11;
    localparam int GroupWidth   = 13;
    localparam int GroupCount   = 4;
    localparam int LzWidth      = 6;
    localparam int BaseWidth    = 26;
    localparam int DecWidth     = 11;
    localparam int SlopeWidth   = 11;
    localparam int ProdWidth    = DecWidth + SlopeWidth;
    localparam int MantShift    = 26;

    localparam logic [ExpWidth-1:0]     ExpMax     = 11'h7FF;
    localparam logic [OperandWidth-1:0] QnanDefault = 64'h7FF8_0000_0000_0000;
    localparam logic [OperandWidth-1:0] QuietBit    = 64'h0008_0000_0000_0000;
    localparam logic [11:0]             ExpBias2    = 12'd3068;

    // stage A: classification and per-group leading zero counts
    typedef struct packed {
        logic                         special;
        logic [OperandWidth-1:0]      spec_val;
        logic                         is_den;
        logic [ExpWidth-1:0]          exp;
        logic [FracWidth-1:0]         frac;
        logic [GroupCount-1:0][3:0]   grp_cnt;
        logic [GroupCount-1:0]        grp_nz;
    } cls_t;

    // stage B: full leading zero count
    typedef struct packed {
        logic                    special;
        logic [OperandWidth-1:0] spec_val;
        logic                    is_den;
        logic [ExpWidth-1:0]     exp;
        logic [FracWidth-1:0]    frac;
        logic [LzWidth-1:0]      lz;
    } lz_t;

    // stage C: table index, slope and result exponent
    typedef struct packed {
        logic                    special;
        logic [OperandWidth-1:0] spec_val;
        logic [ExpWidth-1:0]     res_exp;
        logic [4:0]              idx;
        logic [SlopeWidth-1:0]   slope;
    } idx_t;

    // stage D: base value and slope product
    typedef struct packed {
        logic                    special;
        logic [OperandWidth-1:0] spec_val;
        logic [ExpWidth-1:0]     res_exp;
        logic [BaseWidth-1:0]    base;
        logic [ProdWidth-1:0]    prod;
    } prod_t;

    function automatic logic [3:0] lz13(input logic [GroupWidth-1:0] v);
        logic [3:0] cnt;
        logic       found;
        cnt   = 4'd0;
        found = 1'b0;
        for (int i = GroupWidth - 1; i >= 0; i--)
        begin
            if (!found)
            begin
                if (v[i])
                begin
                    found = 1'b1;
                end
                else
                begin
                    cnt = cnt + 4'd1;
                end
            end
        end
        return cnt;
    endfunction

    function automatic logic [BaseWidth-1:0] rom_base(input logic [4:0] idx);
        logic [BaseWidth-1:0] v;
        case (idx)
            5'd0:    v = 26'h1a7e800;
            5'd1:    v = 26'h17cb800;
            5'd2:    v = 26'h1552800;
            5'd3:    v = 26'h130c000;
            5'd4:    v = 26'h10f2000;
            5'd5:    v = 26'h0eff000;
            5'd6:    v = 26'h0d2e000;
            5'd7:    v = 26'h0b7c000;
            5'd8:    v = 26'h09e5000;
            5'd9:    v = 26'h0867000;
            5'd10:   v = 26'h06ff000;
            5'd11:   v = 26'h05ab800;
            5'd12:   v = 26'h046a000;
            5'd13:   v = 26'h0339800;
            5'd14:   v = 26'h0218800;
            5'd15:   v = 26'h0105800;
            5'd16:   v = 26'h3ffa000;
            5'd17:   v = 26'h3c29000;
            5'd18:   v = 26'h38aa000;
            5'd19:   v = 26'h3572000;
            5'd20:   v = 26'h3279000;
            5'd21:   v = 26'h2fb7000;
            5'd22:   v = 26'h2d26000;
            5'd23:   v = 26'h2ac0000;
            5'd24:   v = 26'h2881000;
            5'd25:   v = 26'h2665000;
            5'd26:   v = 26'h2468000;
            5'd27:   v = 26'h2287000;
            5'd28:   v = 26'h20c1000;
            5'd29:   v = 26'h1f12000;
            5'd30:   v = 26'h1d79000;
            default: v = 26'h1bf4000;
        endcase
        return v;
    endfunction

    function automatic logic [DecWidth-1:0] rom_dec(input logic [4:0] idx);
        logic [DecWidth-1:0] v;
        case (idx)
            5'd0:    v = 11'h568;
            5'd1:    v = 11'h4f3;
            5'd2:    v = 11'h48d;
            5'd3:    v = 11'h435;
            5'd4:    v = 11'h3e7;
            5'd5:    v = 11'h3a2;
            5'd6:    v = 11'h365;
            5'd7:    v = 11'h32e;
            5'd8:    v = 11'h2fc;
            5'd9:    v = 11'h2d0;
            5'd10:   v = 11'h2a8;
            5'd11:   v = 11'h283;
            5'd12:   v = 11'h261;
            5'd13:   v = 11'h243;
            5'd14:   v = 11'h226;
            5'd15:   v = 11'h20b;
            5'd16:   v = 11'h7a4;
            5'd17:   v = 11'h700;
            5'd18:   v = 11'h670;
            5'd19:   v = 11'h5f2;
            5'd20:   v = 11'h584;
            5'd21:   v = 11'h524;
            5'd22:   v = 11'h4cc;
            5'd23:   v = 11'h47e;
            5'd24:   v = 11'h43a;
            5'd25:   v = 11'h3fa;
            5'd26:   v = 11'h3c2;
            5'd27:   v = 11'h38e;
            5'd28:   v = 11'h35e;
            5'd29:   v = 11'h332;
            5'd30:   v = 11'h30a;
            default: v = 11'h2e6;
        endcase
        return v;
    endfunction

endpackage

### hdl/rse_classify.sv
module rse_classify (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [rse_pkg::OperandWidth-1:0]  operand,
    output logic                              out_valid,
    output rse_pkg::cls_t                     out_data
);
    import rse_pkg::*;

    logic                    valid_reg;
    cls_t                    data_reg;
    cls_t                    data_next;
    logic                    sign;
    logic [ExpWidth-1:0]     exp;
    logic [FracWidth-1:0]    frac;

    assign sign = operand[OperandWidth-1];
    assign exp  = operand[FracWidth +: ExpWidth];
    assign frac = operand[FracWidth-1:0];

    always_comb
    begin
        data_next          = '0;
        data_next.is_den   = (exp == '0);
        data_next.exp      = exp;
        data_next.frac     = frac;
        data_next.special  = 1'b1;
        if (exp == '0 && frac == '0)
        begin
            // zero: infinity of the same sign
            data_next.spec_val = {sign, ExpMax, {FracWidth{1'b0}}};
        end
        else if (exp == ExpMax)
        begin
            if (frac == '0)
            begin
                data_next.spec_val = sign ? QnanDefault : '0;
            end
            else
            begin
                data_next.spec_val = operand | QuietBit;
            end
        end
        else if (sign)
        begin
            data_next.spec_val = QnanDefault;
        end
        else
        begin
            data_next.special = 1'b0;
        end
        for (int g = 0; g < GroupCount; g++)
        begin
            data_next.grp_cnt[g] = lz13(frac[FracWidth-1-GroupWidth*g -: GroupWidth]);
            data_next.grp_nz[g]  = |frac[FracWidth-1-GroupWidth*g -: GroupWidth];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### hdl/rse_normalize.sv
module rse_normalize (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  rse_pkg::cls_t  in_data,
    output logic           out_valid,
    output rse_pkg::idx_t  out_data
);
    import rse_pkg::*;

    logic                  lz_valid_reg;
    lz_t                   lz_reg;
    lz_t                   lz_next;
    logic                  idx_valid_reg;
    idx_t                  idx_reg;
    idx_t                  idx_next;
    logic [FracWidth-1:0]  shifted;
    logic [11:0]           exp_diff;

    // merge group counts into the full leading zero count
    always_comb
    begin
        lz_next.special  = in_data.special;
        lz_next.spec_val = in_data.spec_val;
        lz_next.is_den   = in_data.is_den;
        lz_next.exp      = in_data.exp;
        lz_next.frac     = in_data.frac;
        if (in_data.grp_nz[0])
        begin
            lz_next.lz = {2'b00, in_data.grp_cnt[0]};
        end
        else if (in_data.grp_nz[1])
        begin
            lz_next.lz = LzWidth'(GroupWidth) + {2'b00, in_data.grp_cnt[1]};
        end
        else if (in_data.grp_nz[2])
        begin
            lz_next.lz = LzWidth'(2 * GroupWidth) + {2'b00, in_data.grp_cnt[2]};
        end
        else
        begin
            lz_next.lz = LzWidth'(3 * GroupWidth) + {2'b00, in_data.grp_cnt[3]};
        end
    end

    // shift the leading one of a denormal to the top bit; its exponent is -lz
    assign shifted = lz_reg.frac << lz_reg.lz;

    always_comb
    begin
        idx_next.special  = lz_reg.special;
        idx_next.spec_val = lz_reg.spec_val;
        if (lz_reg.is_den)
        begin
            exp_diff       = ExpBias2 + {6'd0, lz_reg.lz};
            idx_next.idx   = {exp_diff[0], shifted[FracWidth-2 -: 4]};
            idx_next.slope = shifted[FracWidth-6 -: SlopeWidth];
        end
        else
        begin
            exp_diff       = ExpBias2 - {1'b0, lz_reg.exp};
            idx_next.idx   = {exp_diff[0], lz_reg.frac[FracWidth-1 -: 4]};
            idx_next.slope = lz_reg.frac[FracWidth-5 -: SlopeWidth];
        end
        idx_next.res_exp = exp_diff[11:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lz_valid_reg  <= 1'b0;
            idx_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            lz_valid_reg  <= in_valid;
            idx_valid_reg <= lz_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lz_reg  <= lz_next;
            idx_reg <= idx_next;
        end
    end

    assign out_valid = idx_valid_reg;
    assign out_data  = idx_reg;

endmodule

### hdl/rse_mantissa.sv
module rse_mantissa (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  rse_pkg::idx_t                     in_data,
    output logic                              out_valid,
    output logic [rse_pkg::OperandWidth-1:0]  out_bits
);
    import rse_pkg::*;

    logic                    prod_valid_reg;
    prod_t                   prod_reg;
    prod_t                   prod_next;
    logic                    res_valid_reg;
    logic [OperandWidth-1:0] res_reg;
    logic [OperandWidth-1:0] res_next;
    logic [BaseWidth-1:0]    mant;

    always_comb
    begin
        prod_next.special  = in_data.special;
        prod_next.spec_val = in_data.spec_val;
        prod_next.res_exp  = in_data.res_exp;
        prod_next.base     = rom_base(in_data.idx);
        prod_next.prod     = rom_dec(in_data.idx) * in_data.slope;
    end

    // subtract the slope product from the base; wrap to the field width
    assign mant = prod_reg.base - {{(BaseWidth-ProdWidth){1'b0}}, prod_reg.prod};

    always_comb
    begin
        if (prod_reg.special)
        begin
            res_next = prod_reg.spec_val;
        end
        else
        begin
            res_next = {1'b0, prod_reg.res_exp, mant, {MantShift{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= in_valid;
            res_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            res_reg  <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_bits  = res_reg;

endmodule

### hdl/reciprocal_sqrt_estimate.sv
// Reciprocal square root estimate in the frsqrte style: takes the raw bits of an
// IEEE double and returns the raw bits of an estimate of 1/sqrt(x). Zeros give
// infinity of the same sign, +inf gives +0, -inf and negative finite operands
// give the default quiet NaN, and a NaN comes back with its quiet bit set.
// Denormals are normalized before the table lookup. The pipeline has five
// register stages (classify, leading zero merge, shift and index, table and
// multiply, subtract and pack). The edge that takes a transaction loads the
// first stage, and its result is presented on m_tdata from the last stage.
// One operand is accepted every cycle while the output is not stalled. A stall on
// the output freezes the whole pipeline; s_tready is low only while a finished
// result waits on m_tready.
module reciprocal_sqrt_estimate (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rse_pkg::OperandWidth-1:0]  s_tdata,   // [63:0] operand_bits
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rse_pkg::OperandWidth-1:0]  m_tdata    // [63:0] estimate_bits
);
    import rse_pkg::*;

    logic  en;
    logic  cls_valid;
    cls_t  cls_data;
    logic  idx_valid;
    idx_t  idx_data;

    // advance unless the final stage holds a result nobody takes
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    rse_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .operand   (s_tdata),
        .out_valid (cls_valid),
        .out_data  (cls_data)
    );

    rse_normalize u_normalize (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cls_valid),
        .in_data   (cls_data),
        .out_valid (idx_valid),
        .out_data  (idx_data)
    );

    rse_mantissa u_mantissa (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (idx_valid),
        .in_data   (idx_data),
        .out_valid (m_tvalid),
        .out_bits  (m_tdata)
    );

    // an ordinary estimate is positive with the low mantissa bits clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[62:52] != ExpMax && m_tdata[62:52] != '0
        |-> !m_tdata[63] && m_tdata[25:0] == '0)
        else $error("ordinary estimate malformed");

    // a stall freezes the middle of the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(idx_valid) && $stable(cls_valid))
        else $error("pipeline moved during stall");

    // an accepted transaction is loaded into the first stage's valid
    assert property (@(posedge clk) disable iff (!rst_n)
        en && s_tvalid |=> cls_valid)
        else $error("accepted transaction lost in first stage");

endmodule
